// ===== rtl/core/bdeq_pkg.sv =====
package bdeq_pkg;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_POP_FRONT  = 2'd1,
        OP_PUSH_REAR  = 2'd2,
        OP_POP_REAR   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    localparam int unsigned VALUE_BITS = 32;
    localparam int unsigned COUNT_BITS = 4;

    typedef struct packed {
        t_opcode                       opcode;
        logic signed [VALUE_BITS-1:0]  value;
    } t_in_word;

    typedef struct packed {
        t_status                       status;
        logic signed [VALUE_BITS-1:0]  popped_value;
        logic                          is_empty;
        logic                          is_full;
        logic [COUNT_BITS-1:0]         entry_count;
    } t_out_word;

    typedef struct packed {
        logic accept;
        logic exec;
    } t_dp_cmd;

endpackage

// ===== rtl/core/bdeq_ram.sv =====
module bdeq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bdeq_ctrl.sv =====
module bdeq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_strobe,
    output bdeq_pkg::t_dp_cmd o_cmd
);

    import bdeq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_strobe;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_EXEC);
        end
    end

    assign busy         = (r_state == S_EXEC);
    assign o_strobe     = r_strobe;
    assign o_cmd.accept = start && (r_state == S_IDLE);
    assign o_cmd.exec   = (r_state == S_EXEC);

endmodule

// ===== rtl/core/bdeq_dp.sv =====
module bdeq_dp #(
    parameter int unsigned DEPTH     = 8,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bdeq_pkg::t_dp_cmd   i_cmd,
    input  bdeq_pkg::t_in_word  i_word,
    output bdeq_pkg::t_out_word o_result
);

    import bdeq_pkg::*;

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);

    logic [IDX_W-1:0]     r_front, n_front;
    logic [IDX_W-1:0]     r_rear, n_rear;
    logic                 r_empty, n_empty;
    t_opcode              r_op;
    logic [WORD_BITS-1:0] r_value;
    t_out_word            r_result;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [IDX_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    t_status              status;
    logic [WORD_BITS-1:0] popped;
    logic [IDX_W:0]       count;

    assign ram_raddr = (i_word.opcode == OP_POP_FRONT) ? r_front : r_rear;

    bdeq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_value),
        .i_re    (i_cmd.accept),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_front   = r_front;
        n_rear    = r_rear;
        n_empty   = r_empty;
        status    = ST_DONE;
        popped    = '0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        unique case (r_op) inside
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (r_empty) begin
                    n_front = '0;
                    n_rear  = '0;
                    n_empty = 1'b0;
                    ram_we  = i_cmd.exec;
                end else if (r_op == OP_PUSH_FRONT) begin
                    if (r_front == '0) begin
                        status = ST_NO_SPACE;
                    end else begin
                        n_front   = r_front - 1'b1;
                        ram_waddr = n_front;
                        ram_we    = i_cmd.exec;
                    end
                end else begin
                    if (r_rear == LAST_SLOT) begin
                        status = ST_NO_SPACE;
                    end else begin
                        n_rear    = r_rear + 1'b1;
                        ram_waddr = n_rear;
                        ram_we    = i_cmd.exec;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
                if (r_empty) begin
                    status = ST_UNDERFLOW;
                end else begin
                    popped = ram_rdata;
                    if (r_front == r_rear) begin
                        n_front = '0;
                        n_rear  = '0;
                        n_empty = 1'b1;
                    end else if (r_op == OP_POP_FRONT) begin
                        n_front = r_front + 1'b1;
                    end else begin
                        n_rear = r_rear - 1'b1;
                    end
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
        count = {1'b0, n_rear} - {1'b0, n_front} + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_rear  <= n_rear;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_word.opcode;
            r_value <= WORD_BITS'($unsigned(i_word.value));
        end
        if (i_cmd.exec) begin
            r_result.status       <= status;
            r_result.popped_value <= VALUE_BITS'(popped);
            r_result.is_empty     <= n_empty;
            r_result.is_full      <= !n_empty && (n_front == '0) && (n_rear == LAST_SLOT);
            r_result.entry_count  <= n_empty ? '0 : COUNT_BITS'(count);
        end
    end

    assign o_result = r_result;

endmodule

// ===== rtl/core/bounded_double_ended_queue.sv =====
// An accepted word executes in S_EXEC; o_result and o_strobe are loaded as it ends.
// A new word is not accepted while busy; busy is high for the cycle after acceptance,
// while the slot RAM's registered read is consumed and the indices are updated.
// o_strobe is high for one cycle; o_result then holds; the receiver cannot stall it.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
module bounded_double_ended_queue #(
    parameter int unsigned DEPTH     = 8,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  bdeq_pkg::t_in_word  i_cmd,
    output logic                o_strobe,
    output bdeq_pkg::t_out_word o_result
);

    import bdeq_pkg::*;

    t_dp_cmd dp_cmd;

    bdeq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (dp_cmd)
    );

    bdeq_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_word   (i_cmd),
        .o_result (o_result)
    );

endmodule

// ===== tb/tb_bounded_double_ended_queue.sv =====
module tb_bounded_double_ended_queue;
    import bdeq_pkg::*;

    localparam int unsigned DEPTH      = 8;
    localparam int          IDLE_LIMIT = 1000;
    localparam int          RAND_WORDS = 600;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    logic       busy;
    t_in_word   i_cmd   = '0;
    logic       o_strobe;
    t_out_word  o_result;

    bit         idle_on = 1'b1;
    int         idle_cycles = 0;

    class deque_shadow;
        logic [VALUE_BITS-1:0] slots [DEPTH];
        int unsigned           front_slot = 0;
        int unsigned           rear_slot  = 0;
        bit                    is_empty   = 1'b1;
        t_out_word             due_results [$];
        int                    mismatches = 0;

        function t_out_word apply_op(t_in_word w);
            t_out_word r;
            r        = '0;
            r.status = ST_DONE;
            case (w.opcode) inside
                OP_PUSH_FRONT, OP_PUSH_REAR: begin
                    if (is_empty) begin
                        front_slot = 0;
                        rear_slot  = 0;
                        slots[0]   = w.value;
                        is_empty   = 1'b0;
                    end else if (w.opcode == OP_PUSH_FRONT) begin
                        if (front_slot == 0) begin
                            r.status = ST_NO_SPACE;
                        end else begin
                            front_slot--;
                            slots[front_slot] = w.value;
                        end
                    end else begin
                        if (rear_slot == DEPTH - 1) begin
                            r.status = ST_NO_SPACE;
                        end else begin
                            rear_slot++;
                            slots[rear_slot] = w.value;
                        end
                    end
                end
                default: begin
                    if (is_empty) begin
                        r.status = ST_UNDERFLOW;
                    end else begin
                        if (w.opcode == OP_POP_FRONT) begin
                            r.popped_value = slots[front_slot];
                        end else begin
                            r.popped_value = slots[rear_slot];
                        end
                        if (front_slot == rear_slot) begin
                            is_empty   = 1'b1;
                            front_slot = 0;
                            rear_slot  = 0;
                        end else if (w.opcode == OP_POP_FRONT) begin
                            front_slot++;
                        end else begin
                            rear_slot--;
                        end
                    end
                end
            endcase
            r.is_empty = is_empty;
            if (!is_empty) begin
                r.entry_count = COUNT_BITS'(rear_slot - front_slot + 1);
                r.is_full     = (front_slot == 0) && (rear_slot == DEPTH - 1);
            end
            return r;
        endfunction

        function void note_word(t_in_word w);
            due_results.push_back(apply_op(w));
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no word pending: st=%0d pop=%h e=%0b f=%0b n=%0d",
                             got.status, got.popped_value, got.is_empty, got.is_full,
                             got.entry_count);
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status || got.popped_value !== want.popped_value ||
                got.is_empty !== want.is_empty || got.is_full !== want.is_full ||
                got.entry_count !== want.entry_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected st=%0d pop=%h e=%0b f=%0b n=%0d, ",
                              "got st=%0d pop=%h e=%0b f=%0b n=%0d"},
                             want.status, want.popped_value, want.is_empty, want.is_full,
                             want.entry_count, got.status, got.popped_value, got.is_empty,
                             got.is_full, got.entry_count);
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    deque_shadow shadow = new;

    bounded_double_ended_queue #(
        .DEPTH     (DEPTH),
        .WORD_BITS (VALUE_BITS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) shadow.note_word(i_cmd);
            if (o_strobe) shadow.check_result(o_result);
        end
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_bounded_double_ended_queue failed");
            $finish;
        end
    end

    task automatic send_word(input t_opcode op, input logic [VALUE_BITS-1:0] value);
        t_in_word w;
        int       gap;
        w.opcode = op;
        w.value  = value;
        gap      = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= w;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int       push_pct;
        t_opcode  op;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // underflow, push into empty, no space at either end, fill, drain
        send_word(OP_POP_FRONT, 32'hffff_ffff);
        send_word(OP_POP_REAR, 32'h1234_5678);
        send_word(OP_PUSH_REAR, 32'h8000_0000);
        send_word(OP_PUSH_FRONT, 32'h0000_0001);
        send_word(OP_PUSH_REAR, 32'h7fff_ffff);
        send_word(OP_PUSH_REAR, 32'hffff_ffff);
        send_word(OP_PUSH_REAR, 32'h0000_0000);
        send_word(OP_PUSH_REAR, 32'h5555_5555);
        send_word(OP_PUSH_REAR, 32'haaaa_aaaa);
        send_word(OP_PUSH_REAR, 32'h0000_0001);
        send_word(OP_PUSH_REAR, 32'hdead_beef);
        send_word(OP_PUSH_REAR, 32'h0f0f_0f0f);
        send_word(OP_PUSH_FRONT, 32'hf0f0_f0f0);
        send_word(OP_POP_FRONT, 32'h0);
        send_word(OP_POP_FRONT, 32'h0);
        send_word(OP_PUSH_FRONT, 32'h3333_3333);
        send_word(OP_PUSH_FRONT, 32'hcccc_cccc);
        repeat (8) send_word(OP_POP_REAR, $urandom);
        send_word(OP_POP_REAR, 32'h0);
        send_word(OP_PUSH_FRONT, 32'h7fff_ffff);
        send_word(OP_POP_FRONT, 32'h0);

        push_pct = 50;
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n % 40 == 0) begin
                push_pct = 30 + 20 * $urandom_range(0, 2);
                idle_on  = $urandom_range(0, 2) != 0;
            end
            if ($urandom_range(1, 100) <= push_pct) begin
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
            end else begin
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
            end
            send_word(op, pick_value());
        end
        start <= 1'b0;

        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.pending() == 0) begin
            $display("tb_bounded_double_ended_queue passed");
        end else begin
            $display("tb_bounded_double_ended_queue failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bdeq_pkg.sv
rtl/core/bdeq_ram.sv
rtl/core/bdeq_ctrl.sv
rtl/core/bdeq_dp.sv
rtl/core/bounded_double_ended_queue.sv
tb/tb_bounded_double_ended_queue.sv
